// ===== src/record_slot_allocator_unit_defines.svh =====
// -----------------------------------------------------------------------------
// Record slot allocator assertion macros
// Shared concurrent assertion forms for the slot allocator RTL.
// -----------------------------------------------------------------------------
`ifndef RECORD_SLOT_ALLOCATOR_UNIT_DEFINES_SVH
`define RECORD_SLOT_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RSA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rsa assertion failed");

// next-cycle implication, checked out of reset
`define RSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rsa assertion failed");

`endif

// ===== src/rsa_pkg.sv =====
// -----------------------------------------------------------------------------
// Record slot allocator package
// Widths, codes, entry layout and helper functions for the slot allocator.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsa_pkg;

   localparam int PAGES  = 256;
   localparam int SLOTS  = 64;
   localparam int PAGE_W = $clog2(PAGES);
   localparam int PTR_W  = $clog2(PAGES + 1);
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int FUNC_W = 2;
   localparam int STAT_W = 3;

   localparam logic [FUNC_W-1:0] FUNC_CHECK     = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_INSERT    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_INSERT_AT = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_DELETE    = 2'd3;

   localparam logic [STAT_W-1:0] STAT_OK           = 3'd0;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND    = 3'd1;
   localparam logic [STAT_W-1:0] STAT_NO_PAGE      = 3'd2;
   localparam logic [STAT_W-1:0] STAT_BAD_SLOT     = 3'd3;
   localparam logic [STAT_W-1:0] STAT_OCCUPIED     = 3'd4;
   localparam logic [STAT_W-1:0] STAT_NO_FREE      = 3'd5;
   localparam logic [STAT_W-1:0] STAT_OUT_OF_PAGES = 3'd6;

   localparam logic [PTR_W-1:0] PTR_NONE  = PTR_W'(PAGES);
   localparam logic [CNT_W-1:0] SPP_RESET = CNT_W'(SLOTS);

   typedef struct packed {
      logic [SLOTS-1:0] slot_map;
      logic [CNT_W-1:0] fill_count;
      logic [PTR_W-1:0] next_free;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [PAGE_W-1:0] page_index;
      logic [SLOT_W-1:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [PAGE_W-1:0] out_page;
      logic [SLOT_W-1:0] out_slot;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [PAGE_W-1:0] wr_addr;
      entry_type         wr_entry;
      logic [PTR_W-1:0]  free_head;
      logic [PTR_W-1:0]  page_count;
      rsp_type           rsp;
   } upd_type;

   function automatic logic [SLOTS-1:0] slot_mask(input logic [CNT_W-1:0] spp);
      logic [SLOTS-1:0] m;
      for (int i = 0; i < SLOTS; i++) begin
         m[i] = (CNT_W'(i) < spp);
      end
      return m;
   endfunction

   function automatic logic [SLOT_W-1:0] first_set(input logic [SLOTS-1:0] v);
      logic [SLOT_W-1:0] idx;
      idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = SLOT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

// ===== src/rsa_if.sv =====
// -----------------------------------------------------------------------------
// Record slot allocator channels
// Valid/ready request and response channels of the slot allocator.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rsa_req_if;
   import rsa_pkg::*;

   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [PAGE_W-1:0] page_index;
   logic [SLOT_W-1:0] slot_index;

   modport source (output valid, output func, output page_index, output slot_index,
                   input ready);
   modport sink   (input valid, input func, input page_index, input slot_index,
                   output ready);
endinterface

interface rsa_rsp_if;
   import rsa_pkg::*;

   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [PAGE_W-1:0] out_page;
   logic [SLOT_W-1:0] out_slot;

   modport source (output valid, output status, output out_page, output out_slot,
                   input ready);
   modport sink   (input valid, input status, input out_page, input out_slot,
                   output ready);
endinterface

`default_nettype wire

// ===== src/rsa_ram.sv =====
// -----------------------------------------------------------------------------
// Record slot allocator RAM
// Generic single-write, single-read synchronous RAM with registered read.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/rsa_update.sv =====
// -----------------------------------------------------------------------------
// Record slot allocator update logic
// Modify step: decodes the request against the page entry read from RAM and
// forms the write-back entry, free-list head, page count and response.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsa_update (
   input  wire rsa_pkg::req_type              req,
   input  wire rsa_pkg::entry_type            rd_entry,
   input  wire logic [rsa_pkg::PTR_W-1:0]     free_head,
   input  wire logic [rsa_pkg::PTR_W-1:0]     page_count,
   input  wire logic [rsa_pkg::CNT_W-1:0]     spp,
   output rsa_pkg::upd_type                   upd
);
   import rsa_pkg::*;

   logic             head_none;
   logic             create;
   logic [PTR_W-1:0] head_page;
   logic [PTR_W-1:0] count_eff;
   entry_type        ent;
   logic [SLOTS-1:0] avail;
   logic [SLOT_W-1:0] free_slot;
   logic [CNT_W-1:0] fill_inc;
   logic [CNT_W-1:0] fill_dec;
   logic [PTR_W-1:0] pg_ext;
   logic             pg_ok;
   logic             slot_ok;
   logic             slot_bit;
   logic             ins_ok;

   always_comb begin
      head_none = (free_head >= PTR_NONE);
      create    = (req.func == FUNC_INSERT) && head_none && (page_count < PTR_NONE);
      head_page = head_none ? page_count : free_head;
      count_eff = create ? page_count + PTR_W'(1) : page_count;
      if (create) begin
         ent.slot_map   = '0;
         ent.fill_count = '0;
         ent.next_free  = PTR_NONE;
      end else begin
         ent = rd_entry;
      end
      avail     = ~ent.slot_map & slot_mask(spp);
      free_slot = first_set(avail);
      fill_inc  = ent.fill_count + CNT_W'(1);
      fill_dec  = (ent.fill_count != '0) ? ent.fill_count - CNT_W'(1) : '0;
      pg_ext    = {1'b0, req.page_index};
      pg_ok     = (pg_ext != '0) && (pg_ext < page_count);
      slot_ok   = ({1'b0, req.slot_index} < spp);
      slot_bit  = ent.slot_map[req.slot_index];
      ins_ok    = (head_page != '0) && (head_page < count_eff) && (avail != '0);

      upd.wr_en        = 1'b0;
      upd.wr_addr      = req.page_index;
      upd.wr_entry     = ent;
      upd.free_head    = free_head;
      upd.page_count   = page_count;
      upd.rsp.status   = STAT_OK;
      upd.rsp.out_page = req.page_index;
      upd.rsp.out_slot = req.slot_index;

      if (req.func == FUNC_INSERT) begin
         upd.wr_addr      = head_page[PAGE_W-1:0];
         upd.rsp.out_page = head_page[PAGE_W-1:0];
         upd.rsp.out_slot = '0;
         if (head_none && !create) begin
            upd.rsp.status   = STAT_OUT_OF_PAGES;
            upd.rsp.out_page = '0;
         end else begin
            if (create) begin
               upd.wr_en      = 1'b1;
               upd.page_count = count_eff;
               upd.free_head  = head_page;
            end
            if ((head_page == '0) || (head_page >= count_eff)) begin
               upd.rsp.status = STAT_NO_PAGE;
            end else if (avail == '0) begin
               upd.rsp.status = STAT_NO_FREE;
            end
            if (ins_ok) begin
               upd.wr_en                    = 1'b1;
               upd.wr_entry.slot_map[free_slot] = 1'b1;
               upd.wr_entry.fill_count      = fill_inc;
               upd.rsp.out_slot             = free_slot;
               if (fill_inc >= spp) begin
                  upd.free_head = ent.next_free;
               end
            end
         end
      end else if (!pg_ok) begin
         upd.rsp.status = STAT_NO_PAGE;
      end else if (!slot_ok) begin
         upd.rsp.status = STAT_BAD_SLOT;
      end else begin
         case (req.func)
            FUNC_CHECK: begin
               if (!slot_bit) begin
                  upd.rsp.status = STAT_NOT_FOUND;
               end
            end
            FUNC_INSERT_AT: begin
               if (slot_bit) begin
                  upd.rsp.status = STAT_OCCUPIED;
               end else begin
                  upd.wr_en                           = 1'b1;
                  upd.wr_entry.slot_map[req.slot_index] = 1'b1;
                  upd.wr_entry.fill_count             = fill_inc;
                  if ((fill_inc >= spp) && (free_head == pg_ext)) begin
                     upd.free_head = ent.next_free;
                  end
               end
            end
            FUNC_DELETE: begin
               if (!slot_bit) begin
                  upd.rsp.status = STAT_NOT_FOUND;
               end else begin
                  upd.wr_en                           = 1'b1;
                  upd.wr_entry.slot_map[req.slot_index] = 1'b0;
                  upd.wr_entry.fill_count             = fill_dec;
                  if (ent.fill_count >= spp) begin
                     upd.wr_entry.next_free = free_head;
                     upd.free_head          = pg_ext;
                  end
               end
            end
            default: begin
               upd.rsp.status = STAT_NO_PAGE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== src/record_slot_allocator_unit.sv =====
// -----------------------------------------------------------------------------
// Record slot allocator unit
// Two-level slotted-page bitmap allocator: per-page entries in one RAM, the
// free-list head and page count in registers.
// -----------------------------------------------------------------------------
// For each request word, the accept cycle issues the RAM read of the addressed
// page (or the free-list head page), and the next cycle modifies the entry,
// writes it back and loads the response register. One request is in flight at
// a time; a new word is accepted once the response register is empty or being
// drained and the previous word has been written back. The page RAM needs no
// clearing after reset: an entry is written when its page is created, before
// any request can address it. csr_wr_data is clamped to 1..64 slots per page
// when written.
`timescale 1ns / 1ps
`default_nettype none

`include "record_slot_allocator_unit_defines.svh"

module record_slot_allocator_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   rsa_req_if.sink                          req_bus,
   rsa_rsp_if.source                        rsp_bus,
   input  wire logic                        csr_wr_en,
   input  wire logic [rsa_pkg::CNT_W-1:0]   csr_wr_data
);
   import rsa_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [PTR_W-1:0] free_head_ff, free_head_in;
   logic [PTR_W-1:0] page_count_ff, page_count_in;
   logic [CNT_W-1:0] spp_ff, spp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             accept;
   logic [PAGE_W-1:0] rd_addr;
   entry_type        rd_entry;
   upd_type          upd;
   logic             ram_wr_en;

   assign req_bus.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;
   assign rd_addr       = (req_bus.func == FUNC_INSERT) ? free_head_ff[PAGE_W-1:0]
                                                        : req_bus.page_index;
   assign ram_wr_en     = (state_ff == ST_EXEC) && upd.wr_en;

   rsa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (PAGES)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (upd.wr_addr),
      .wr_data (upd.wr_entry),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   rsa_update u_update (
      .req        (req_ff),
      .rd_entry   (rd_entry),
      .free_head  (free_head_ff),
      .page_count (page_count_ff),
      .spp        (spp_ff),
      .upd        (upd)
   );

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      free_head_in  = free_head_ff;
      page_count_in = page_count_ff;
      spp_in        = spp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_in        = rsp_ff;

      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            spp_in = CNT_W'(1);
         end else if (csr_wr_data > SPP_RESET) begin
            spp_in = SPP_RESET;
         end else begin
            spp_in = csr_wr_data;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in.func       = req_bus.func;
               req_in.page_index = req_bus.page_index;
               req_in.slot_index = req_bus.slot_index;
               state_in          = ST_EXEC;
            end
         end
         ST_EXEC: begin
            free_head_in  = upd.free_head;
            page_count_in = upd.page_count;
            rsp_in        = upd.rsp;
            rsp_valid_in  = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_head_ff  <= PTR_NONE;
         page_count_ff <= PTR_W'(1);
         spp_ff        <= SPP_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         page_count_ff <= page_count_in;
         spp_ff        <= spp_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.status   = rsp_ff.status;
   assign rsp_bus.out_page = rsp_ff.out_page;
   assign rsp_bus.out_slot = rsp_ff.out_slot;

   `RSA_ASSERT_NEXT(a_exec_loads_rsp, clock, reset, state_ff == ST_EXEC, rsp_valid_ff)
   `RSA_ASSERT_SAME(a_wr_only_in_exec, clock, reset, ram_wr_en, state_ff == ST_EXEC)
   `RSA_ASSERT_SAME(a_head_not_header, clock, reset, 1'b1, free_head_ff != '0)
   `RSA_ASSERT_SAME(a_count_in_range, clock, reset, 1'b1,
                    (page_count_ff != '0) && (page_count_ff <= PTR_NONE))
   `RSA_ASSERT_SAME(a_head_below_count, clock, reset, free_head_ff != PTR_NONE,
                    free_head_ff < page_count_ff)

endmodule

`default_nettype wire
